/* hw/rtl/substring_find_all_unit_macros.svh */
// ----------------------------------------------------------------------------
// substring_find_all_unit assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_FIND_ALL_UNIT_MACROS_SVH
`define SUBSTRING_FIND_ALL_UNIT_MACROS_SVH

// Same-cycle implication.
`define SFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("substring_find_all_unit: same-cycle check failed");

// Next-cycle implication.
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("substring_find_all_unit: next-cycle check failed");

`endif

/* hw/rtl/sfa_pkg.sv */
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared constants and types of the substring search unit.
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_TEXT    = 65536;

    localparam int BYTE_W  = 8;
    localparam int PAT_W   = MAX_PATTERN * BYTE_W;
    localparam int LEN_W   = 4;
    localparam int PIDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int WIN_D   = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int POS_W   = $clog2(MAX_TEXT);
    localparam int IDX_W   = 16;
    localparam int CNT_W   = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte that produces a result
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] start;
        logic             last;
        logic             ovf;
    } sfa_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sfa_qstat_t;

endpackage

/* hw/rtl/sfa_front.sv */
// ----------------------------------------------------------------------------
// sfa_front
// Takes text bytes, compares the pattern against the byte window and queues
// a request for every byte that completes a match or ends the text.
// ----------------------------------------------------------------------------
module sfa_front
    import sfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PAT_W-1:0]  pattern_bytes,
    input  logic [LEN_W-1:0]  pattern_length,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              last_byte,
    input  sfa_qstat_t        q_stat,
    output logic              q_push,
    output sfa_entry_t        q_entry
);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT - 1);

    logic [BYTE_W-1:0] window_reg  [WIN_D];
    logic [BYTE_W-1:0] window_next [WIN_D];
    logic [POS_W-1:0]  position_reg, position_next;
    logic              overflowed_reg, overflowed_next;

    logic                accept;
    logic                len_ok;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic                hit;
    logic                ovf_now;
    logic [POS_W-1:0]    start_pos;
    logic [POS_W+IDX_W-1:0] start_ext;
    logic [BYTE_W-1:0]   recent [MAX_PATTERN];
    logic [PIDX_W-1:0]   pidx   [MAX_PATTERN];

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // recent[0] is the current byte, recent[k] the byte k places back
    always_comb
    begin
        recent[0] = text_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            recent[k] = window_reg[k-1];
        end
    end

    always_comb
    begin
        len_ok = (pattern_length != '0)
              && ({1'b0, pattern_length} <= (LEN_W+1)'(MAX_PATTERN))
              && (({1'b0, position_reg} + (POS_W+1)'(1)) >= (POS_W+1)'(pattern_length));
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            pidx[k]    = PIDX_W'(pattern_length - LEN_W'(1) - LEN_W'(k));
            byte_ok[k] = (LEN_W'(k) >= pattern_length)
                      || (pattern_bytes[pidx[k]*BYTE_W +: BYTE_W] == recent[k]);
        end
        hit       = len_ok && (&byte_ok);
        start_pos = position_reg - POS_W'(pattern_length) + POS_W'(1);
        start_ext = {{IDX_W{1'b0}}, start_pos};
        ovf_now   = overflowed_reg || ((position_reg == POS_MAX) && !last_byte);
    end

    always_comb
    begin
        q_push        = accept && (hit || last_byte);
        q_entry.hit   = hit;
        q_entry.start = hit ? start_ext[IDX_W-1:0] : '0;
        q_entry.last  = last_byte;
        q_entry.ovf   = ovf_now;
    end

    always_comb
    begin
        window_next     = window_reg;
        position_next   = position_reg;
        overflowed_next = overflowed_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                for (int k = 0; k < WIN_D; k++)
                begin
                    window_next[k] = '0;
                end
                position_next   = '0;
                overflowed_next = 1'b0;
            end
            else
            begin
                window_next[0] = text_byte;
                for (int k = 1; k < WIN_D; k++)
                begin
                    window_next[k] = window_reg[k-1];
                end
                if (position_reg != POS_MAX)
                begin
                    position_next = position_reg + POS_W'(1);
                end
                overflowed_next = ovf_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_D; k++)
            begin
                window_reg[k] <= '0;
            end
            position_reg   <= '0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            window_reg     <= window_next;
            position_reg   <= position_next;
            overflowed_reg <= overflowed_next;
        end
    end

endmodule

/* hw/rtl/sfa_queue.sv */
// ----------------------------------------------------------------------------
// sfa_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module sfa_queue
    import sfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sfa_entry_t push_entry,
    input  logic       pop,
    output sfa_entry_t head_entry,
    output sfa_qstat_t stat
);

    sfa_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/sfa_back.sv */
// ----------------------------------------------------------------------------
// sfa_back
// Keeps the per-text match count and first start, and builds each result in
// the output register.
// ----------------------------------------------------------------------------
module sfa_back
    import sfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  sfa_entry_t       head_entry,
    input  sfa_qstat_t       q_stat,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             match_found,
    output logic [IDX_W-1:0] match_start,
    output logic [CNT_W-1:0] match_total,
    output logic [IDX_W-1:0] first_start,
    output logic             none_found,
    output logic             done_res,
    output logic             overflow
);

    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic             seen_reg, seen_next;

    logic             valid_reg, valid_next;
    logic             found_reg;
    logic [IDX_W-1:0] start_reg;
    logic [CNT_W-1:0] total_reg;
    logic [IDX_W-1:0] fstart_reg;
    logic             none_reg;
    logic             done_reg;
    logic             ovf_reg;

    logic [CNT_W-1:0] occ_upd;
    logic [IDX_W-1:0] first_upd;
    logic             seen_upd;

    assign q_pop = !q_stat.empty && (!valid_reg || out_ready);

    always_comb
    begin
        occ_upd   = (head_entry.hit && (occ_reg != '1)) ? occ_reg + CNT_W'(1) : occ_reg;
        first_upd = (head_entry.hit && !seen_reg) ? head_entry.start : first_reg;
        seen_upd  = seen_reg || head_entry.hit;

        occ_next   = occ_reg;
        first_next = first_reg;
        seen_next  = seen_reg;
        valid_next = valid_reg && !out_ready;
        if (q_pop)
        begin
            valid_next = 1'b1;
            if (head_entry.last)
            begin
                occ_next   = '0;
                first_next = '0;
                seen_next  = 1'b0;
            end
            else
            begin
                occ_next   = occ_upd;
                first_next = first_upd;
                seen_next  = seen_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            first_reg <= '0;
            seen_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg   <= occ_next;
            first_reg <= first_next;
            seen_reg  <= seen_next;
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            found_reg  <= head_entry.hit;
            start_reg  <= head_entry.start;
            total_reg  <= occ_upd;
            fstart_reg <= first_upd;
            none_reg   <= head_entry.last && !seen_upd;
            done_reg   <= head_entry.last;
            ovf_reg    <= head_entry.ovf;
        end
    end

    assign out_valid   = valid_reg;
    assign match_found = found_reg;
    assign match_start = start_reg;
    assign match_total = total_reg;
    assign first_start = fstart_reg;
    assign none_found  = none_reg;
    assign done_res    = done_reg;
    assign overflow    = ovf_reg;

endmodule

/* hw/rtl/substring_find_all_unit.sv */
// ----------------------------------------------------------------------------
// substring_find_all_unit
// Streaming search for every occurrence of a pattern of up to eight bytes.
// ----------------------------------------------------------------------------
// Text enters one byte per request on s_axis, tlast on the final byte. Every
// byte is checked against the configured pattern in the cycle it is taken,
// using a window of the previous seven bytes, so the unit sustains one byte
// per clock while the queue is not full; the compare and the queue push
// happen in that same cycle, and the result register sits behind the queue. A result
// request leaves when an occurrence ends at a byte (match_found set, with
// its start index) or when the byte is final (done, carried on tlast, with
// the total, the first start and none_found). Bytes that do neither give no
// result. Only bytes of the current text take part in a match. Positions
// saturate at MAX_TEXT-1, and the overflow flag marks texts longer than MAX_TEXT bytes.
// pattern_length 0 or above 8 never matches. Write the pattern (index 0) and
// its length (index 1) over cfg only while the unit is idle; other indexes
// are ignored. A two-entry queue parts the front compare from the result
// register, so a stalled m_axis holds s_axis off only once the queue fills.
// ----------------------------------------------------------------------------
`include "substring_find_all_unit_macros.svh"

module substring_find_all_unit
    import sfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAT_W-1:0]     cfg_data,
    // text stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] text_byte
    input  logic                 s_axis_tlast,   // last_byte
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // [15:0] match_start, [31:16] match_total,
                                                 // [47:32] first_start
    output logic [2:0]           m_axis_tuser,   // [0] match_found, [1] none_found,
                                                 // [2] overflow
    output logic                 m_axis_tlast    // done_res
);

    logic [PAT_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;

    sfa_qstat_t       q_stat;
    sfa_entry_t       push_entry;
    sfa_entry_t       head_entry;
    logic             q_push;
    logic             q_pop;

    logic             match_found;
    logic [IDX_W-1:0] match_start;
    logic [CNT_W-1:0] match_total;
    logic [IDX_W-1:0] first_start;
    logic             none_found;
    logic             done_res;
    logic             overflow;

    // Config registers: always ready, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    sfa_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .pattern_bytes  (pattern_bytes_reg),
        .pattern_length (pattern_length_reg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .text_byte      (s_axis_tdata),
        .last_byte      (s_axis_tlast),
        .q_stat         (q_stat),
        .q_push         (q_push),
        .q_entry        (push_entry)
    );

    sfa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .stat       (q_stat)
    );

    sfa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_entry  (head_entry),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .match_found (match_found),
        .match_start (match_start),
        .match_total (match_total),
        .first_start (first_start),
        .none_found  (none_found),
        .done_res    (done_res),
        .overflow    (overflow)
    );

    assign m_axis_tdata = {first_start, match_total, match_start};
    assign m_axis_tuser = {overflow, none_found, match_found};
    assign m_axis_tlast = done_res;

    // Text side only stalls when the queue is full
    `SFA_ASSERT_IMPL(a_stall_only_full, clk, rst_n, !s_axis_tready, q_stat.full)
    // A match always counts at least one occurrence
    `SFA_ASSERT_IMPL(a_match_counted, clk, rst_n, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[31:16] != 16'd0)
    // No-match report only at end of text, with nothing counted
    `SFA_ASSERT_IMPL(a_none_consistent, clk, rst_n, m_axis_tvalid && m_axis_tuser[1],
        m_axis_tlast && !m_axis_tuser[0] && (m_axis_tdata[31:16] == 16'd0))

endmodule
